### rtl/tcha_pkg.sv
// Shared types and constants of the triangle classifier and Heron area unit.
`timescale 1ns / 1ps
`default_nettype none

package tcha_pkg;

  localparam int unsigned PERIM_W = 17;
  localparam int unsigned AREA_W  = 29;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_EQUI    = 2'd1,
    KIND_ISO     = 2'd2,
    KIND_SCALENE = 2'd3
  } kind_e;

  typedef struct packed {
    logic                 buildable;
    kind_e                kind;
    logic [PERIM_W-1:0]   perimeter;
  } info_t;

  typedef struct packed {
    logic                 buildable;
    kind_e                kind;
    logic [PERIM_W-1:0]   perimeter;
    logic [AREA_W-1:0]    area;
  } result_t;

endpackage

`default_nettype wire

### rtl/tcha_if.sv
// Valid/ready channel interfaces for the side word and the result word.
`timescale 1ns / 1ps
`default_nettype none

interface tcha_in_if #(
  parameter int unsigned SIDE_WIDTH = 15
);
  logic                  valid;
  logic                  ready;
  logic [SIDE_WIDTH-1:0] side_a;
  logic [SIDE_WIDTH-1:0] side_b;
  logic [SIDE_WIDTH-1:0] side_c;

  modport source (output valid, output side_a, output side_b, output side_c, input ready);
  modport sink   (input valid, input side_a, input side_b, input side_c, output ready);
endinterface

interface tcha_out_if import tcha_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               buildable;
  logic [1:0]         kind;
  logic [PERIM_W-1:0] perimeter;
  logic [AREA_W-1:0]  area;

  modport source (output valid, output buildable, output kind, output perimeter,
                  output area, input ready);
  modport sink   (input valid, input buildable, input kind, input perimeter,
                  input area, output ready);
endinterface

`default_nettype wire

### rtl/tcha_front.sv
// Front stages: side sums, triangle inequality, classification and Heron factors.
`timescale 1ns / 1ps
`default_nettype none

module tcha_front import tcha_pkg::*; #(
  parameter int unsigned SIDE_WIDTH = 15
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic                  valid_i,
  input  wire logic [SIDE_WIDTH-1:0] side_a_i,
  input  wire logic [SIDE_WIDTH-1:0] side_b_i,
  input  wire logic [SIDE_WIDTH-1:0] side_c_i,
  output logic                       valid_o,
  output info_t                      info_o,
  output logic [SIDE_WIDTH+1:0]      per_o,
  output logic [SIDE_WIDTH:0]        f1_o,
  output logic [SIDE_WIDTH:0]        f2_o,
  output logic [SIDE_WIDTH:0]        f3_o
);

  localparam int unsigned W  = SIDE_WIDTH;
  localparam int unsigned SW = W + 1;
  localparam int unsigned PW = W + 2;

  logic          va_q;
  logic [W-1:0]  a_q, b_q, c_q;
  logic [SW-1:0] sbc_q, sac_q, sab_q;

  logic          vb_q;
  info_t         info_q, info_d;
  logic [PW-1:0] per_q, per_d;
  logic [SW-1:0] f1_q, f1_d, f2_q, f2_d, f3_q, f3_d;

  logic ok, eq_ab, eq_ac, eq_bc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q   <= side_a_i;
      b_q   <= side_b_i;
      c_q   <= side_c_i;
      sbc_q <= SW'(side_b_i) + SW'(side_c_i);
      sac_q <= SW'(side_a_i) + SW'(side_c_i);
      sab_q <= SW'(side_a_i) + SW'(side_b_i);
      info_q <= info_d;
      per_q  <= per_d;
      f1_q   <= f1_d;
      f2_q   <= f2_d;
      f3_q   <= f3_d;
    end
  end

  always_comb begin
    ok    = (SW'(a_q) < sbc_q) && (SW'(b_q) < sac_q) && (SW'(c_q) < sab_q);
    eq_ab = (a_q == b_q);
    eq_ac = (a_q == c_q);
    eq_bc = (b_q == c_q);
    info_d = '0;
    per_d  = '0;
    f1_d   = '0;
    f2_d   = '0;
    f3_d   = '0;
    if (ok) begin
      per_d = PW'(a_q) + PW'(sbc_q);
      f1_d  = sbc_q - SW'(a_q);
      f2_d  = sac_q - SW'(b_q);
      f3_d  = sab_q - SW'(c_q);
      info_d.buildable = 1'b1;
      info_d.perimeter = PERIM_W'(per_d);
      if (eq_ab && eq_ac) begin
        info_d.kind = KIND_EQUI;
      end else if (eq_ab || eq_ac || eq_bc) begin
        info_d.kind = KIND_ISO;
      end else begin
        info_d.kind = KIND_SCALENE;
      end
    end
  end

  assign valid_o = vb_q;
  assign info_o  = info_q;
  assign per_o   = per_q;
  assign f1_o    = f1_q;
  assign f2_o    = f2_q;
  assign f3_o    = f3_q;

endmodule

`default_nettype wire

### rtl/tcha_mul.sv
// Multiplier stages that form the Heron product of the perimeter and three factors.
`timescale 1ns / 1ps
`default_nettype none

module tcha_mul import tcha_pkg::*; #(
  parameter int unsigned SIDE_WIDTH = 15
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire logic                    valid_i,
  input  wire info_t                   info_i,
  input  wire logic [SIDE_WIDTH+1:0]   per_i,
  input  wire logic [SIDE_WIDTH:0]     f1_i,
  input  wire logic [SIDE_WIDTH:0]     f2_i,
  input  wire logic [SIDE_WIDTH:0]     f3_i,
  output logic                         valid_o,
  output info_t                        info_o,
  output logic [4*SIDE_WIDTH+3:0]      prod_o
);

  localparam int unsigned W   = SIDE_WIDTH;
  localparam int unsigned XW  = 2 * W + 3;
  localparam int unsigned YW  = 2 * W + 2;
  localparam int unsigned H   = W + 1;
  localparam int unsigned HW  = YW - H;
  localparam int unsigned LW  = XW + H;
  localparam int unsigned UW  = XW + HW;
  localparam int unsigned PRW = 4 * W + 4;

  logic           vc_q, vd_q, ve_q;
  info_t          infoc_q, infod_q, infoe_q;
  logic [XW-1:0]  x_q;
  logic [YW-1:0]  y_q;
  logic [LW-1:0]  mlo_q;
  logic [UW-1:0]  mhi_q;
  logic [PRW-1:0] p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else if (en_i) begin
      vc_q <= valid_i;
      vd_q <= vc_q;
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      infoc_q <= info_i;
      x_q     <= XW'(per_i) * XW'(f1_i);
      y_q     <= YW'(f2_i) * YW'(f3_i);
      infod_q <= infoc_q;
      mlo_q   <= LW'(x_q) * LW'(y_q[H-1:0]);
      mhi_q   <= UW'(x_q) * UW'(y_q[YW-1:H]);
      infoe_q <= infod_q;
      p_q     <= PRW'(mlo_q) + (PRW'(mhi_q) << H);
    end
  end

  assign valid_o = ve_q;
  assign info_o  = infoe_q;
  assign prod_o  = p_q;

endmodule

`default_nettype wire

### rtl/tcha_sqrt.sv
// Pipelined integer square root that settles one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module tcha_sqrt import tcha_pkg::*; #(
  parameter int unsigned SIDE_WIDTH = 15
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire logic                    valid_i,
  input  wire info_t                   info_i,
  input  wire logic [4*SIDE_WIDTH+3:0] prod_i,
  output logic                         valid_o,
  output info_t                        info_o,
  output logic [2*SIDE_WIDTH+1:0]      root_o
);

  localparam int unsigned PRW   = 4 * SIDE_WIDTH + 4;
  localparam int unsigned N     = PRW / 2;
  localparam int unsigned RW    = N;
  localparam int unsigned REM_W = RW + 2;
  localparam int unsigned CW    = REM_W + 2;

  logic              v_q    [N];
  info_t             info_q [N];
  logic [PRW-1:0]    rad_q  [N];
  logic [REM_W-1:0]  rem_q  [N];
  logic [RW-1:0]     root_q [N];

  logic              v_in    [N];
  info_t             info_in [N];
  logic [PRW-1:0]    rad_in  [N];
  logic [REM_W-1:0]  rem_in  [N];
  logic [RW-1:0]     root_in [N];

  logic [CW-1:0]     cur     [N];
  logic [CW-1:0]     trial   [N];
  logic              take    [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    if (i == 0) begin : g_first
      assign v_in[i]    = valid_i;
      assign info_in[i] = info_i;
      assign rad_in[i]  = prod_i;
      assign rem_in[i]  = '0;
      assign root_in[i] = '0;
    end else begin : g_next
      assign v_in[i]    = v_q[i-1];
      assign info_in[i] = info_q[i-1];
      assign rad_in[i]  = rad_q[i-1];
      assign rem_in[i]  = rem_q[i-1];
      assign root_in[i] = root_q[i-1];
    end

    assign cur[i]   = {rem_in[i], rad_in[i][PRW-1:PRW-2]};
    assign trial[i] = CW'({root_in[i], 2'b01});
    assign take[i]  = (cur[i] >= trial[i]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        info_q[i] <= info_in[i];
        rad_q[i]  <= rad_in[i] << 2;
        if (take[i]) begin
          rem_q[i]  <= REM_W'(cur[i] - trial[i]);
          root_q[i] <= {root_in[i][RW-2:0], 1'b1};
        end else begin
          rem_q[i]  <= REM_W'(cur[i]);
          root_q[i] <= {root_in[i][RW-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign info_o  = info_q[N-1];
  assign root_o  = root_q[N-1];

endmodule

`default_nettype wire

### rtl/triangle_classify_heron_area_top.sv
// Top level of the triangle classifier with Heron area.
//
// Each word on in_i carries three unsigned side lengths. For each accepted word,
// exactly one result word leaves on out_o, in order: the buildable flag, the kind
// (equilateral, isosceles or scalene), the perimeter and floor(sqrt(P)/4) as the
// area. A triangle that fails the strict inequality yields an all-zero result.
// Throughput is one word per cycle while the skid is empty. From acceptance to
// out_o.valid a word passes two front stages, three multiplier stages, one square
// root stage per root bit and the output register.
// The square root pipeline, one root bit per stage, sets the depth.
// All stages advance together while the skid register is empty. When the receiver
// holds out_o.ready low, the word in the output register stays put, one more word
// moves on into the skid register, and then in_i.ready drops until the skid drains.
// No word is lost or repeated under any stall pattern.
// Reset clears all valid bits; the block takes a word in the first cycle after it.
`timescale 1ns / 1ps
`default_nettype none

module triangle_classify_heron_area_top import tcha_pkg::*; #(
  parameter int unsigned SIDE_WIDTH = 15
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tcha_in_if.sink    in_i,
  tcha_out_if.source out_o
);

  localparam int unsigned W  = SIDE_WIDTH;
  localparam int unsigned RW = 2 * W + 2;

  logic              en;
  logic              fr_valid, mu_valid, sq_valid;
  info_t             fr_info, mu_info, sq_info;
  logic [W+1:0]      fr_per;
  logic [W:0]        fr_f1, fr_f2, fr_f3;
  logic [4*W+3:0]    mu_prod;
  logic [RW-1:0]     sq_root;
  result_t           res;

  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  result_t           out_q, out_d;
  result_t           skid_q, skid_d;

  assign en        = !skid_valid_q;
  assign in_i.ready = en;

  tcha_front #(.SIDE_WIDTH(SIDE_WIDTH)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_i.valid),
    .side_a_i (in_i.side_a),
    .side_b_i (in_i.side_b),
    .side_c_i (in_i.side_c),
    .valid_o  (fr_valid),
    .info_o   (fr_info),
    .per_o    (fr_per),
    .f1_o     (fr_f1),
    .f2_o     (fr_f2),
    .f3_o     (fr_f3)
  );

  tcha_mul #(.SIDE_WIDTH(SIDE_WIDTH)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .info_i  (fr_info),
    .per_i   (fr_per),
    .f1_i    (fr_f1),
    .f2_i    (fr_f2),
    .f3_i    (fr_f3),
    .valid_o (mu_valid),
    .info_o  (mu_info),
    .prod_o  (mu_prod)
  );

  tcha_sqrt #(.SIDE_WIDTH(SIDE_WIDTH)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (mu_valid),
    .info_i  (mu_info),
    .prod_i  (mu_prod),
    .valid_o (sq_valid),
    .info_o  (sq_info),
    .root_o  (sq_root)
  );

  always_comb begin
    res.buildable = sq_info.buildable;
    res.kind      = sq_info.kind;
    res.perimeter = sq_info.perimeter;
    res.area      = AREA_W'(sq_root[RW-1:2]);
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_o.ready || !out_valid_q) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = res;
        out_valid_d = sq_valid;
      end
    end else if (en && sq_valid) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.buildable = out_q.buildable;
  assign out_o.kind      = out_q.kind;
  assign out_o.perimeter = out_q.perimeter;
  assign out_o.area      = out_q.area;

endmodule

`default_nettype wire

### rtl/tcha_checker.sv
// Port-level checker of the triangle classifier and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tcha_checker import tcha_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_ready_i,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire logic               out_buildable_i,
  input wire logic [1:0]         out_kind_i,
  input wire logic [PERIM_W-1:0] out_perimeter_i,
  input wire logic [AREA_W-1:0]  out_area_i
);

  // A stalled result word stays valid until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  // A triangle that cannot be built reports all-zero fields.
  a_unbuildable_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_buildable_i |->
      out_kind_i == KIND_NONE && out_perimeter_i == '0 && out_area_i == '0)
    else $error("unbuildable triangle with nonzero fields");

  // A buildable triangle always has a kind and a nonzero perimeter.
  a_buildable_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_buildable_i |-> out_kind_i != KIND_NONE && out_perimeter_i != '0)
    else $error("buildable triangle without kind or perimeter");

  // The input side only stalls after the output side was stalled.
  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> $past(out_valid_i && !out_ready_i))
    else $error("input stalled without an output stall");

endmodule

bind triangle_classify_heron_area_top tcha_checker u_tcha_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_buildable_i (out_o.buildable),
  .out_kind_i      (out_o.kind),
  .out_perimeter_i (out_o.perimeter),
  .out_area_i      (out_o.area)
);

`default_nettype wire
